>>> hw/rtl/text_console_writer_assert.svh
// Assertion macros for the text console writer.
// Expects clk and rst_n in the scope of use; no other dependencies.
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH
`ifndef SYNTHESIS
`define TCW_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("tcw assertion failed");
`define TCW_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tcw assertion failed");
`else
`define TCW_ASSERT_ALWAYS(lbl, cond)
`define TCW_ASSERT_IMPLY(lbl, ante, cons)
`endif
`endif

>>> hw/rtl/tcw_pkg.sv
// Shared types and constants for the text console writer.
// No dependencies.
package tcw_pkg;

  typedef enum logic [2:0] {
    CMD_PUT_CHAR   = 3'd0,
    CMD_BACKSPACE  = 3'd1,
    CMD_MARK_LINE  = 3'd2,
    CMD_CLEAR      = 3'd3,
    CMD_HOME       = 3'd4,
    CMD_PUT_AT     = 3'd5,
    CMD_SET_HW_CUR = 3'd6,
    CMD_READ_CELL  = 3'd7
  } cmd_t;

  localparam logic [7:0]  CHAR_NEWLINE = 8'd10;
  localparam logic [7:0]  CHAR_BLANK   = 8'h20;
  localparam logic [15:0] ATTR_WHITE   = 16'h0F00;

  // decoded word passed from front to back
  typedef struct packed {
    cmd_t              cmd;
    logic [7:0]        char_code;
    logic signed [6:0] row;
    logic signed [7:0] col;
    logic              on_screen;
  } item_t;

  // back-end status seen by the front
  typedef struct packed {
    logic sweeping;
    logic idle;
  } exec_stat_t;

endpackage

>>> hw/rtl/tcw_in_if.sv
// Command channel of the text console writer.
// Depends on nothing.
interface tcw_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        cmd;
  logic [7:0]        char_code;
  logic signed [6:0] row;
  logic signed [7:0] col;
  modport source (output valid, cmd, char_code, row, col, input ready);
  modport sink   (input valid, cmd, char_code, row, col, output ready);
endinterface

>>> hw/rtl/tcw_out_if.sv
// Result channel of the text console writer.
// Depends on nothing.
interface tcw_out_if #(parameter int CELL_W = 11);
  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] hw_cursor_cell;
  logic [15:0]       cell_value;
  modport source (output valid, hw_cursor_cell, cell_value, input ready);
  modport sink   (input valid, hw_cursor_cell, cell_value, output ready);
endinterface

>>> hw/rtl/tcw_front.sv
// Front end: accepts command words, checks positions, queues them.
// Depends on tcw_pkg and tcw_in_if.
module tcw_front #(
  parameter int ROWS    = 25,
  parameter int COLUMNS = 80
) (
  input  logic                clk,
  input  logic                rst_n,
  tcw_in_if.sink              in_ch,
  input  tcw_pkg::exec_stat_t stat,
  output tcw_pkg::item_t      q_item,
  output logic                q_valid,
  input  logic                q_pop
);

  tcw_pkg::item_t fifo_r [2];
  logic           wr_ptr_r, rd_ptr_r;
  logic [1:0]     count_r;
  logic           push;
  tcw_pkg::item_t item_c;

  // no new words while the back end sweeps memory
  assign in_ch.ready = (count_r != 2'd2) && !stat.sweeping;
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (count_r != 2'd0);
  assign q_item      = fifo_r[rd_ptr_r];

  // classify the word
  always_comb begin
    item_c.cmd       = tcw_pkg::cmd_t'(in_ch.cmd);
    item_c.char_code = in_ch.char_code;
    item_c.row       = in_ch.row;
    item_c.col       = in_ch.col;
    item_c.on_screen = !in_ch.row[6] && ({1'b0, in_ch.row[5:0]} < 7'(ROWS)) &&
                       !in_ch.col[7] && ({2'b0, in_ch.col[6:0]} < 9'(COLUMNS));
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= item_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (q_pop) rd_ptr_r <= !rd_ptr_r;
      count_r <= count_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule

>>> hw/rtl/tcw_exec.sv
// Back end: screen memory, cursor state, sweeps and the result register.
// Depends on tcw_pkg and tcw_out_if.
module tcw_exec #(
  parameter int ROWS    = 25,
  parameter int COLUMNS = 80,
  parameter int CELL_W  = 11
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tcw_pkg::item_t      q_item,
  input  logic                q_valid,
  output logic                q_pop,
  output tcw_pkg::exec_stat_t stat,
  tcw_out_if.source           out_ch
);

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int ROW_W  = $clog2(ROWS + 1);
  localparam int COL_W  = $clog2(COLUMNS + 1);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_RDWAIT = 3'b010,
    ST_SWEEP  = 3'b100
  } state_t;

  logic [7:0] mem_r [CELLS];
  logic [7:0] rd_data_r;

  state_t             st_r, st_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt, top_r, top_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [CELL_W-1:0]  cell_r, cell_nxt, ls_r, ls_nxt, hw_r, hw_nxt;
  logic [ADDR_W-1:0]  sw_addr_r, sw_addr_nxt, sw_last_r, sw_last_nxt;
  logic               rd_ok_r, rd_ok_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [CELL_W-1:0]  out_hw_r, out_hw_nxt;
  logic [15:0]        out_val_r, out_val_nxt;

  logic               we_c;
  logic [7:0]         wd_c;
  logic [ROW_W-1:0]   pr_c, rc_c;
  logic [COL_W-1:0]   pc_c, cc_c;
  logic [ROW_W:0]     prow_sum;
  logic [ROW_W-1:0]   prow_c;
  logic [ADDR_W-1:0]  pa_c, wa_c, base_c;

  assign q_pop = (st_r == ST_IDLE) && q_valid && !out_valid_r;
  assign stat.sweeping = (st_r == ST_SWEEP);
  assign stat.idle     = (st_r == ST_IDLE);

  assign out_ch.valid          = out_valid_r;
  assign out_ch.hw_cursor_cell = out_hw_r;
  assign out_ch.cell_value     = out_val_r;

  // logical row to physical row of the ring
  assign prow_sum = {1'b0, pr_c} + {1'b0, top_r};
  assign prow_c   = (prow_sum >= (ROW_W+1)'(ROWS)) ?
                    ROW_W'(prow_sum - (ROW_W+1)'(ROWS)) : ROW_W'(prow_sum);
  assign pa_c     = ADDR_W'(prow_c * COLUMNS + pc_c);
  assign base_c   = ADDR_W'(top_r * COLUMNS);
  assign wa_c     = (st_r == ST_SWEEP) ? sw_addr_r : pa_c;

  // clamped hardware cursor position
  assign rc_c = q_item.row[6] ? '0 :
                ({1'b0, q_item.row[5:0]} >= 7'(ROWS)) ? ROW_W'(ROWS - 1) :
                ROW_W'(q_item.row[5:0]);
  assign cc_c = q_item.col[7] ? '0 :
                ({2'b0, q_item.col[6:0]} >= 9'(COLUMNS)) ? COL_W'(COLUMNS - 1) :
                COL_W'(q_item.col[6:0]);

  always_comb begin
    st_nxt        = st_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    cell_nxt      = cell_r;
    ls_nxt        = ls_r;
    hw_nxt        = hw_r;
    top_nxt       = top_r;
    sw_addr_nxt   = sw_addr_r;
    sw_last_nxt   = sw_last_r;
    rd_ok_nxt     = rd_ok_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_hw_nxt    = out_hw_r;
    out_val_nxt   = out_val_r;
    we_c          = 1'b0;
    wd_c          = tcw_pkg::CHAR_BLANK;
    pr_c          = row_r;
    pc_c          = col_r;
    case (st_r)
      ST_IDLE: begin
        if (q_pop) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = '0;
          case (q_item.cmd)
            tcw_pkg::CMD_PUT_CHAR: begin
              if (q_item.char_code == tcw_pkg::CHAR_NEWLINE) begin
                row_nxt  = row_r + 1'b1;
                col_nxt  = '0;
                cell_nxt = cell_r - CELL_W'(col_r) + CELL_W'(COLUMNS);
              end else begin
                we_c     = 1'b1;
                wd_c     = q_item.char_code;
                cell_nxt = cell_r + 1'b1;
                if (col_r == COL_W'(COLUMNS - 1)) begin
                  row_nxt = row_r + 1'b1;
                  col_nxt = '0;
                end else begin
                  col_nxt = col_r + 1'b1;
                end
              end
              // ran off the bottom: scroll by moving the ring top
              if (row_nxt == ROW_W'(ROWS)) begin
                row_nxt     = ROW_W'(ROWS - 1);
                cell_nxt    = cell_nxt - CELL_W'(COLUMNS);
                if (ls_r >= CELL_W'(COLUMNS)) ls_nxt = ls_r - CELL_W'(COLUMNS);
                top_nxt     = (top_r == ROW_W'(ROWS - 1)) ? '0 : top_r + 1'b1;
                sw_addr_nxt = base_c;
                sw_last_nxt = base_c + ADDR_W'(COLUMNS - 1);
                st_nxt      = ST_SWEEP;
              end
              hw_nxt = cell_nxt;
            end
            tcw_pkg::CMD_BACKSPACE: begin
              if (cell_r > ls_r) begin
                if (col_r == '0) begin
                  row_nxt = row_r - 1'b1;
                  col_nxt = COL_W'(COLUMNS - 1);
                end else begin
                  col_nxt = col_r - 1'b1;
                end
                pr_c     = row_nxt;
                pc_c     = col_nxt;
                we_c     = 1'b1;
                cell_nxt = cell_r - 1'b1;
                hw_nxt   = cell_nxt;
              end
            end
            tcw_pkg::CMD_MARK_LINE: begin
              ls_nxt = cell_r;
            end
            tcw_pkg::CMD_CLEAR: begin
              row_nxt     = '0;
              col_nxt     = '0;
              cell_nxt    = '0;
              ls_nxt      = '0;
              hw_nxt      = '0;
              top_nxt     = '0;
              sw_addr_nxt = '0;
              sw_last_nxt = ADDR_W'(CELLS - 1);
              st_nxt      = ST_SWEEP;
            end
            tcw_pkg::CMD_HOME: begin
              row_nxt  = '0;
              col_nxt  = '0;
              cell_nxt = '0;
              ls_nxt   = '0;
              hw_nxt   = '0;
            end
            tcw_pkg::CMD_PUT_AT: begin
              pr_c = ROW_W'(q_item.row[5:0]);
              pc_c = COL_W'(q_item.col[6:0]);
              we_c = q_item.on_screen;
              wd_c = q_item.char_code;
            end
            tcw_pkg::CMD_SET_HW_CUR: begin
              hw_nxt = CELL_W'(rc_c * COLUMNS + cc_c);
            end
            tcw_pkg::CMD_READ_CELL: begin
              pr_c          = ROW_W'(q_item.row[5:0]);
              pc_c          = COL_W'(q_item.col[6:0]);
              rd_ok_nxt     = q_item.on_screen;
              out_valid_nxt = 1'b0;
              st_nxt        = ST_RDWAIT;
            end
            default: begin
            end
          endcase
          out_hw_nxt = hw_nxt;
        end
      end
      ST_RDWAIT: begin
        out_valid_nxt = 1'b1;
        out_hw_nxt    = hw_r;
        out_val_nxt   = rd_ok_r ? (tcw_pkg::ATTR_WHITE | {8'h00, rd_data_r}) : '0;
        st_nxt        = ST_IDLE;
      end
      ST_SWEEP: begin
        we_c = 1'b1;
        if (sw_addr_r == sw_last_r) begin
          st_nxt = ST_IDLE;
        end else begin
          sw_addr_nxt = sw_addr_r + 1'b1;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  // screen memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we_c) begin
      mem_r[wa_c] <= wd_c;
    end
    rd_data_r <= mem_r[pa_c];
  end

  // payload registers
  always_ff @(posedge clk) begin
    out_hw_r  <= out_hw_nxt;
    out_val_r <= out_val_nxt;
    rd_ok_r   <= rd_ok_nxt;
  end

  // control state; reset starts a blanking pass over the whole screen
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_SWEEP;
      sw_addr_r   <= '0;
      sw_last_r   <= ADDR_W'(CELLS - 1);
      row_r       <= '0;
      col_r       <= '0;
      cell_r      <= '0;
      ls_r        <= '0;
      hw_r        <= '0;
      top_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      sw_addr_r   <= sw_addr_nxt;
      sw_last_r   <= sw_last_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      cell_r      <= cell_nxt;
      ls_r        <= ls_nxt;
      hw_r        <= hw_nxt;
      top_r       <= top_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> hw/rtl/text_console_writer.sv
// Text console writer: ROWS x COLUMNS character screen with write cursor.
// Command words arrive on in_ch (cmd, char_code, row, col); each yields one
// result word on out_ch: the hardware cursor cell and, for read_cell, the
// attribute 0x0F with the stored character (zero otherwise).
// A front end queues up to two words; the back end executes them against a
// ring-organised screen memory and holds the result in an output register,
// so the sender can still queue up to two words while the receiver stalls.
// Most commands execute straight from the idle state; read_cell goes through
// a read-wait state (registered memory read). A scroll blanks COLUMNS cells
// and clear ROWS*COLUMNS cells, one memory write per cycle for the row or
// screen being blanked; the result is issued at the start while the
// blanking continues. The next word starts only once the previous result
// has been taken and the back end is idle again; results pass through the
// queue and the output register, read_cell also through the read register.
// After reset the block blanks all ROWS*COLUMNS cells of the screen with
// in_ch.ready low; cursor, line start and hardware cursor are 0.
// Depends on tcw_pkg, tcw_in_if, tcw_out_if, tcw_front, tcw_exec.
`include "text_console_writer_assert.svh"
module text_console_writer #(
  parameter int ROWS    = 25,
  parameter int COLUMNS = 80
) (
  input  logic       clk,
  input  logic       rst_n,
  tcw_in_if.sink     in_ch,
  tcw_out_if.source  out_ch
);

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int CELL_W = $clog2(CELLS + 1);

  tcw_pkg::item_t      q_item;
  logic                q_valid, q_pop;
  tcw_pkg::exec_stat_t stat;

  tcw_front #(.ROWS(ROWS), .COLUMNS(COLUMNS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .stat    (stat),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  tcw_exec #(.ROWS(ROWS), .COLUMNS(COLUMNS), .CELL_W(CELL_W)) u_exec (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .stat    (stat),
    .out_ch  (out_ch)
  );

  // checks
  `TCW_ASSERT_IMPLY(a_hw_on_screen, out_ch.valid, out_ch.hw_cursor_cell < CELL_W'(CELLS))
  `TCW_ASSERT_IMPLY(a_attr, out_ch.valid && |out_ch.cell_value, out_ch.cell_value[15:8] == 8'h0F)
  `TCW_ASSERT_IMPLY(a_pop_needs_word, q_pop, q_valid && stat.idle)

endmodule
